>>> hdl/mmbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbh_pkg
// Shared constants, types and lookup functions for the multiply-mix byte hash.
// ----------------------------------------------------------------------------
package mmbh_pkg;

    localparam logic [63:0] SECRET0 = 64'h2d358dccaa6c78a5;
    localparam logic [63:0] SECRET1 = 64'h8bb84b93962eacc9;
    localparam logic [63:0] SECRET2 = 64'h4b33a62ed433d4a3;
    localparam logic [63:0] SECRET3 = 64'h4d5a2da51de1aa47;
    localparam logic [63:0] SECRET4 = 64'ha0761d6478bd642f;
    localparam logic [63:0] SECRET5 = 64'he7037ed1a0b428db;
    localparam logic [63:0] SECRET6 = 64'h90ed1765281c388c;
    localparam logic [63:0] SECRET7 = 64'haaaaaaaaaaaaaaaa;

    localparam int CHUNK_BYTES = 112;
    localparam int SHORT_SHIFT = 45;
    localparam int NUM_LANES   = 7;

    // configuration register indexes
    localparam logic CFG_HASH_SEED     = 1'b0;
    localparam logic CFG_PROTECTED_MIX = 1'b1;

    // ring write request: up to eight bytes at a byte address
    typedef struct packed {
        logic        en;
        logic [6:0]  base;
        logic [3:0]  cnt;
        logic [63:0] data;
    } t_ring_wr;

    // multiplier request and response
    typedef struct packed {
        logic        start;
        logic        prot;
        logic [63:0] x;
        logic [63:0] y;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] xo;
        logic [63:0] yo;
    } t_mul_rsp;

    function automatic logic [63:0] lane_secret(input logic [2:0] l);
        logic [63:0] s;
        case (l)
            3'd0:    s = SECRET0;
            3'd1:    s = SECRET1;
            3'd2:    s = SECRET2;
            3'd3:    s = SECRET3;
            3'd4:    s = SECRET4;
            3'd5:    s = SECRET5;
            default: s = SECRET6;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] tail_secret(input logic [2:0] t);
        logic [63:0] s;
        case (t)
            3'd0, 3'd1, 3'd4: s = SECRET2;
            default:          s = SECRET1;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/mmbh_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbh_ring
// 128-byte history ring as eight byte banks of sixteen rows; writes up to
// eight bytes and reads eight consecutive bytes at any alignment per cycle.
// ----------------------------------------------------------------------------
module mmbh_ring (
    input  logic                i_clk,
    input  mmbh_pkg::t_ring_wr  i_wr,
    input  logic [6:0]          i_rd_addr,
    output logic [63:0]         o_rd_data
);
    import mmbh_pkg::*;

    logic [7:0] r_bank [8][16];
    logic [7:0] r_rd_byte [8];
    logic [2:0] r_rd_lo;

    // per bank write and read
    for (genvar j = 0; j < 8; j++) begin : g_bank
        logic [2:0] wk;
        logic [6:0] wa;
        logic [2:0] rk;
        logic [6:0] ra;
        assign wk = 3'(j) - i_wr.base[2:0];
        assign wa = i_wr.base + {4'd0, wk};
        assign rk = 3'(j) - i_rd_addr[2:0];
        assign ra = i_rd_addr + {4'd0, rk};

        always_ff @(posedge i_clk) begin
            if (i_wr.en && ({1'b0, wk} < i_wr.cnt)) begin
                r_bank[j][wa[6:3]] <= i_wr.data[8*wk +: 8];
            end
            r_rd_byte[j] <= r_bank[j][ra[6:3]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_lo <= i_rd_addr[2:0];
    end

    // rotate banks back into byte order
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            o_rd_data[8*k +: 8] = r_rd_byte[3'(r_rd_lo + 3'(k))];
        end
    end

endmodule

>>> hdl/mmbh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmbh_mul
// Shared 64x64 multiply-fold unit: four 32x32 partial products in turn,
// then the low/high halves replace or are xored into the operands.
// ----------------------------------------------------------------------------
module mmbh_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mmbh_pkg::t_mul_req  i_req,
    output mmbh_pkg::t_mul_rsp  o_rsp,
    output logic                o_busy
);
    import mmbh_pkg::*;

    logic         r_busy, r_done, r_pv, r_prot;
    logic [2:0]   r_cnt;
    logic [1:0]   r_psel;
    logic [63:0]  r_x, r_y, r_pp;
    logic [127:0] r_acc;
    logic [31:0]  op_a, op_b;
    logic [127:0] n_acc;

    // partial product operand select
    always_comb begin
        op_a = r_cnt[1] ? r_x[63:32] : r_x[31:0];
        op_b = r_cnt[0] ? r_y[63:32] : r_y[31:0];
    end

    // accumulate at the product's weight
    always_comb begin
        case (r_psel)
            2'd0:    n_acc = r_acc + {64'd0, r_pp};
            2'd3:    n_acc = r_acc + {r_pp, 64'd0};
            default: n_acc = r_acc + {32'd0, r_pp, 32'd0};
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt[2]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_pv   <= 1'b0;
                end else begin
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_req.x;
            r_y    <= i_req.y;
            r_prot <= i_req.prot;
            r_acc  <= '0;
        end else begin
            if (r_busy && !r_cnt[2]) begin
                r_pp   <= op_a * op_b;
                r_psel <= r_cnt[1:0];
            end
            if (r_pv) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.xo   = r_prot ? (r_x ^ r_acc[63:0])   : r_acc[63:0];
    assign o_rsp.yo   = r_prot ? (r_y ^ r_acc[127:64]) : r_acc[127:64];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("multiply done without work");

endmodule

>>> hdl/multiply_mix_byte_hash_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_mix_byte_hash_64
// 64-bit multiply-mix hash of a streamed byte key, one shared multiplier
// under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  key in  | input     | i_valid / o_ready   | i_key_word, i_valid_bytes, i_last_word
//  hash out| output    | o_valid / i_ready   | o_hash_value
//  config  | input     | i_cfg_we            | i_cfg_index, i_cfg_data
//
//  A plain word passes through dispatch; the first word of a key adds a premix
//  multiply. A 112-byte chunk costs seven lane steps, each of two ring reads,
//  a multiplier request and a wait for its result.
//  The last word adds a finish step, up to six tail steps, then the final multiplies.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A waiting hash stalls only the final multiply of the following key.
// ----------------------------------------------------------------------------
module multiply_mix_byte_hash_64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_key_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import mmbh_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_PRE     = 5'd1;
    localparam logic [4:0] S_PRE_W   = 5'd2;
    localparam logic [4:0] S_DISP    = 5'd3;
    localparam logic [4:0] S_ABS_RD0 = 5'd4;
    localparam logic [4:0] S_ABS_RD1 = 5'd5;
    localparam logic [4:0] S_ABS_MUL = 5'd6;
    localparam logic [4:0] S_ABS_W   = 5'd7;
    localparam logic [4:0] S_FIN     = 5'd8;
    localparam logic [4:0] S_TL_RD0  = 5'd9;
    localparam logic [4:0] S_TL_RD1  = 5'd10;
    localparam logic [4:0] S_TL_MUL  = 5'd11;
    localparam logic [4:0] S_TL_W    = 5'd12;
    localparam logic [4:0] S_FRD0    = 5'd13;
    localparam logic [4:0] S_FRD1    = 5'd14;
    localparam logic [4:0] S_FRD2    = 5'd15;
    localparam logic [4:0] S_FMUL1   = 5'd16;
    localparam logic [4:0] S_FW1     = 5'd17;
    localparam logic [4:0] S_FMUL2   = 5'd18;
    localparam logic [4:0] S_FW2     = 5'd19;

    logic [4:0]  r_state;
    logic [63:0] r_seed;
    logic        r_prot;
    logic [63:0] r_lane [NUM_LANES];
    logic [6:0]  r_pend, r_head;
    logic        r_bulk, r_last, r_ov;
    logic [2:0]  r_idx;
    logic [63:0] r_w0, r_sd, r_rd0, r_rd1, r_a, r_b, r_hash;

    t_ring_wr    ring_wr;
    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;
    logic        mul_busy;
    logic [6:0]  rd_off, rd_addr;
    logic [63:0] rd_data;
    logic        accept;
    logic [3:0]  vb;
    logic        n_long;
    logic [6:0]  off0, off1, off2;
    logic [63:0] fin_a, fin_b, len64, lane_fold;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign vb = i_valid_bytes[3] ? 4'd8 : i_valid_bytes;
    assign len64 = {57'd0, r_pend};
    assign n_long = r_bulk || (r_pend > 7'd16);

    // key bytes go straight into the ring at accept
    always_comb begin
        ring_wr.en   = accept;
        ring_wr.base = r_head + r_pend;
        ring_wr.cnt  = vb;
        ring_wr.data = i_key_word;
    end

    // final read offsets relative to the ring head
    always_comb begin
        off2 = {1'b0, r_pend[6:1]};
        if (n_long) begin
            off0 = r_pend - 7'd16;
            off1 = r_pend - 7'd8;
        end else begin
            off0 = 7'd0;
            if (r_pend >= 7'd8)      off1 = r_pend - 7'd8;
            else if (r_pend >= 7'd4) off1 = r_pend - 7'd4;
            else                     off1 = r_pend - 7'd1;
        end
    end

    // ring read address by step
    always_comb begin
        case (r_state)
            S_ABS_RD0: rd_off = {r_idx, 4'd0};
            S_ABS_RD1: rd_off = {r_idx, 4'd8};
            S_TL_RD0:  rd_off = {r_idx, 4'd0};
            S_TL_RD1:  rd_off = {r_idx, 4'd8};
            S_FRD0:    rd_off = off0;
            S_FRD1:    rd_off = off1;
            default:   rd_off = off2;
        endcase
        rd_addr = r_head + rd_off;
    end

    // final a and b words
    always_comb begin
        if (n_long) begin
            fin_a = r_rd0 ^ len64;
            fin_b = r_rd1;
        end else if (r_pend >= 7'd8) begin
            fin_a = r_rd0;
            fin_b = r_rd1;
        end else if (r_pend >= 7'd4) begin
            fin_a = {32'd0, r_rd0[31:0]};
            fin_b = {32'd0, r_rd1[31:0]};
        end else if (r_pend != 7'd0) begin
            fin_a = ({56'd0, r_rd0[7:0]} << SHORT_SHIFT) | {56'd0, r_rd1[7:0]};
            fin_b = {56'd0, rd_data[7:0]};
        end else begin
            fin_a = '0;
            fin_b = '0;
        end
    end

    assign lane_fold = r_lane[1] ^ r_lane[2] ^ r_lane[3] ^ r_lane[4]
                     ^ r_lane[5] ^ r_lane[6];

    // multiplier requests
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.prot  = r_prot;
        mul_req.x     = r_a ^ SECRET7;
        mul_req.y     = r_b ^ SECRET1 ^ len64;
        case (r_state)
            S_PRE: begin
                mul_req.start = 1'b1;
                mul_req.x     = r_seed ^ SECRET2;
                mul_req.y     = SECRET1;
            end
            S_ABS_MUL: begin
                mul_req.start = 1'b1;
                mul_req.x     = r_w0 ^ lane_secret(r_idx);
                mul_req.y     = rd_data ^ r_lane[0];
            end
            S_TL_MUL: begin
                mul_req.start = 1'b1;
                mul_req.x     = r_w0 ^ tail_secret(r_idx);
                mul_req.y     = rd_data ^ r_sd;
            end
            S_FMUL1: begin
                mul_req.start = 1'b1;
                mul_req.x     = fin_a ^ SECRET1;
                mul_req.y     = fin_b ^ r_sd;
            end
            S_FMUL2: begin
                mul_req.start = !r_ov;
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_prot <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HASH_SEED:     r_seed <= i_cfg_data;
                CFG_PROTECTED_MIX: r_prot <= i_cfg_data[0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_head  <= '0;
            r_bulk  <= 1'b0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pend  <= r_pend + {3'd0, vb};
                        r_last  <= i_last_word;
                        r_state <= (r_pend == 7'd0 && !r_bulk) ? S_PRE : S_DISP;
                    end
                end
                S_PRE: r_state <= S_PRE_W;
                S_PRE_W: begin
                    if (mul_rsp.done) begin
                        for (int l = 0; l < NUM_LANES; l++) begin
                            r_lane[l] <= r_seed ^ mul_rsp.xo ^ mul_rsp.yo;
                        end
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_idx <= '0;
                    if (r_pend > 7'(CHUNK_BYTES)) r_state <= S_ABS_RD0;
                    else if (r_last)              r_state <= S_FIN;
                    else                          r_state <= S_IDLE;
                end
                S_ABS_RD0: r_state <= S_ABS_RD1;
                S_ABS_RD1: begin
                    r_w0    <= rd_data;
                    r_state <= S_ABS_MUL;
                end
                S_ABS_MUL: r_state <= S_ABS_W;
                S_ABS_W: begin
                    if (mul_rsp.done) begin
                        // lanes move down as a ring; lane 0 is always next
                        for (int l = 0; l < NUM_LANES - 1; l++) begin
                            r_lane[l] <= r_lane[l + 1];
                        end
                        r_lane[NUM_LANES - 1] <= mul_rsp.xo ^ mul_rsp.yo;
                        if (r_idx == 3'(NUM_LANES - 1)) begin
                            r_head  <= r_head + 7'(CHUNK_BYTES);
                            r_pend  <= r_pend - 7'(CHUNK_BYTES);
                            r_bulk  <= 1'b1;
                            r_state <= r_last ? S_FIN : S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_ABS_RD0;
                        end
                    end
                end
                S_FIN: begin
                    r_idx <= '0;
                    if (r_bulk)                 r_sd <= r_lane[0] ^ lane_fold;
                    else if (r_pend >= 7'd4 && !n_long) r_sd <= r_lane[0] ^ len64;
                    else                        r_sd <= r_lane[0];
                    r_state <= (r_pend > 7'd16) ? S_TL_RD0 : S_FRD0;
                end
                S_TL_RD0: r_state <= S_TL_RD1;
                S_TL_RD1: begin
                    r_w0    <= rd_data;
                    r_state <= S_TL_MUL;
                end
                S_TL_MUL: r_state <= S_TL_W;
                S_TL_W: begin
                    if (mul_rsp.done) begin
                        r_sd  <= mul_rsp.xo ^ mul_rsp.yo;
                        r_idx <= r_idx + 3'd1;
                        if ({1'b0, r_pend} > {1'b0, r_idx + 3'd2, 4'd0})
                            r_state <= S_TL_RD0;
                        else
                            r_state <= S_FRD0;
                    end
                end
                S_FRD0: r_state <= S_FRD1;
                S_FRD1: begin
                    r_rd0   <= rd_data;
                    r_state <= S_FRD2;
                end
                S_FRD2: begin
                    r_rd1   <= rd_data;
                    r_state <= S_FMUL1;
                end
                S_FMUL1: r_state <= S_FW1;
                S_FW1: begin
                    if (mul_rsp.done) begin
                        r_a     <= mul_rsp.xo;
                        r_b     <= mul_rsp.yo;
                        r_state <= S_FMUL2;
                    end
                end
                S_FMUL2: begin
                    if (!r_ov) r_state <= S_FW2;
                end
                S_FW2: begin
                    if (mul_rsp.done) begin
                        r_hash  <= mul_rsp.xo ^ mul_rsp.yo;
                        r_ov    <= 1'b1;
                        r_pend  <= '0;
                        r_head  <= '0;
                        r_bulk  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    mmbh_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mmbh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp),
        .o_busy  (mul_busy)
    );

    assign o_valid      = r_ov;
    assign o_hash_value = r_hash;

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 7'd120)
        else $error("pending byte count out of range");

    a_fin_absorbed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_pend <= 7'(CHUNK_BYTES)))
        else $error("finish entered with an unabsorbed chunk");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_FW2))
        else $error("hash beat raised outside the final step");

    a_wait_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mul_busy)
        else $error("multiplier busy while idle");

endmodule
